@@ src/rdt_pkg.sv @@
// ----------------------------------------------------------------------------
// rdt_pkg: shared types and constants for the RMS drum trigger
// Register indexes, sequencer states and fixed MIDI codes.
// ----------------------------------------------------------------------------
`default_nettype none

package rdt_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 17;

  localparam logic [CfgIdxW-1:0] RegWindowLen  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegHoldoffLen = 3'd1;
  localparam logic [CfgIdxW-1:0] RegThreshold  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegCeiling    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegVelMin     = 3'd4;
  localparam logic [CfgIdxW-1:0] RegVelMax     = 3'd5;
  localparam logic [CfgIdxW-1:0] RegNote       = 3'd6;

  localparam logic [7:0] StatusNoteOff = 8'h80;
  localparam logic [7:0] StatusNoteOn  = 8'h90;

  // 10*log10(2) in Q24
  localparam logic [25:0] DbScale = 26'd50504453;

  typedef enum logic [3:0] {
    StIdle,
    StSquare,
    StAccum,
    StNorm,
    StLogSq,
    StLogStep,
    StLevel,
    StDbMul,
    StVelMul,
    StVelDiv,
    StOutOff,
    StOutOn
  } state_e;

endpackage

`default_nettype wire

@@ src/rms_drum_trigger_core.sv @@
// ----------------------------------------------------------------------------
// rms_drum_trigger_core: RMS level detector firing a drum note
// Sums sample squares over a window, takes the level in dB and on a hit
// sends a note-off followed by a note-on with a scaled velocity.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+------------------------------
//  sample   | in        | sample_valid/stall   | sample_i
//  result   | out       | result_valid/stall   | status_byte, note, velocity, last
//  config   | in        | cfg_we_i             | cfg_idx_i, cfg_data_i
//
//  A sample that only accumulates passes the square and accumulate states. One
//  that evaluates the window adds, at most, the normalising steps (one MSB bit per
//  cycle), the squaring loop for each of the two logarithms, the level, dB and
//  velocity product steps and the velocity divider, with all products on one
//  shared multiplier. Results then wait until taken.
//  Reset clears the window, the hold-off and the registers to their defaults.
//  A stalled result holds the block; no new sample is taken until it drains.
// ----------------------------------------------------------------------------
`default_nettype none

module rms_drum_trigger_core #(
  parameter int unsigned MAX_WINDOW  = 4096,
  parameter int unsigned SAMPLE_BITS = 24
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        sample_valid_i,
  output      logic                        sample_stall_o,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_i,
  output      logic                        result_valid_o,
  input  wire logic                        result_stall_i,
  output      logic [7:0]                  status_byte_o,
  output      logic [6:0]                  note_o,
  output      logic [6:0]                  velocity_o,
  output      logic                        last_o,
  input  wire logic                        cfg_we_i,
  input  wire logic [rdt_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [rdt_pkg::CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned WinW  = $clog2(MAX_WINDOW + 1);
  localparam int unsigned SqW   = 2 * SAMPLE_BITS;
  localparam int unsigned SumW  = 64;
  localparam int unsigned OffsQ = 2 * SAMPLE_BITS - 2;

  // configuration
  logic [12:0] win_len_q;
  logic [15:0] hold_len_q;
  logic signed [16:0] thr_q, ceil_q;
  logic [6:0] vmin_q, vmax_q, note_q;

  // window state
  logic [SumW-1:0] sum_q, sum_d;
  logic [WinW-1:0] fill_q, fill_d;
  logic [15:0] hold_cnt_q, hold_cnt_d;
  logic hold_act_q, hold_act_d;

  // datapath
  rdt_pkg::state_e state_q, state_d;
  logic [SAMPLE_BITS-1:0] mag_q, mag_d;
  logic [SqW-1:0] sq_q, sq_d;
  logic [SumW-1:0] x_q, x_d;          // value being normalised
  logic [6:0] msb_q, msb_d;
  logic [32:0] m_q, m_d;              // Q31 mantissa
  logic [4:0] bit_q, bit_d;
  logic signed [31:0] r_q, r_d;       // accumulated log2 Q16
  logic pass_q, pass_d;               // 0: sum, 1: window length
  logic signed [31:0] lsum_q, lsum_d;
  logic [65:0] prod_q, prod_d;
  logic signed [17:0] db_q, db_d;
  logic [24:0] num_q, num_d;          // division dividend/quotient word
  logic [5:0] cnt_q, cnt_d;
  logic [17:0] rem_q, rem_d;
  logic [6:0] vel_q, vel_d;

  logic [WinW-1:0] eff_n, eff_new;
  logic [WinW-1:0] win_clip;
  logic in_acc, out_acc;

  function automatic logic [WinW-1:0] clip_win(input logic [12:0] w);
    logic [WinW-1:0] r;
    if (w == 13'd0) r = WinW'(1);
    else if (32'(w) > MAX_WINDOW) r = WinW'(MAX_WINDOW);
    else r = WinW'(w);
    return r;
  endfunction

  assign eff_n   = clip_win(win_len_q);
  assign eff_new = clip_win(cfg_data_i[12:0]);
  assign win_clip = eff_n;

  assign sample_stall_o = (state_q != rdt_pkg::StIdle);
  assign in_acc  = sample_valid_i && !sample_stall_o;
  assign out_acc = result_valid_o && !result_stall_i;

  // shared multiplier operands (one 33x33 unit)
  logic [32:0] mul_a, mul_b;
  logic [65:0] mul_p;
  assign mul_p = 66'(mul_a) * 66'(mul_b);

  logic signed [17:0] rlen, dbc, dnum;
  logic signed [8:0] vlen;
  assign rlen = 18'(ceil_q) - 18'(thr_q);
  assign vlen = 9'(signed'({2'b0, vmax_q})) - 9'(signed'({2'b0, vmin_q}));
  assign dbc  = (db_q > 18'(ceil_q)) ? 18'(ceil_q) : db_q;
  assign dnum = dbc - 18'(thr_q);

  logic signed [31:0] lvl;
  assign lvl = lsum_q - r_q - 32'(OffsQ * 65536);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rdt_pkg::StIdle:    if (in_acc) state_d = rdt_pkg::StSquare;
      rdt_pkg::StSquare:  state_d = rdt_pkg::StAccum;
      rdt_pkg::StAccum: begin
        if (!hold_act_q && fill_q >= eff_n && sum_q != '0) state_d = rdt_pkg::StNorm;
        else state_d = rdt_pkg::StIdle;
      end
      rdt_pkg::StNorm:    if (x_q[SumW-1] || msb_q == 7'd0) state_d = rdt_pkg::StLogSq;
      rdt_pkg::StLogSq:   state_d = rdt_pkg::StLogStep;
      rdt_pkg::StLogStep: begin
        if (bit_q != 5'd0) state_d = rdt_pkg::StLogSq;
        else if (!pass_q) state_d = rdt_pkg::StNorm;
        else state_d = rdt_pkg::StLevel;
      end
      rdt_pkg::StLevel:   state_d = rdt_pkg::StDbMul;
      rdt_pkg::StDbMul: begin
        if (db_d < 18'(thr_q)) state_d = rdt_pkg::StIdle;
        else if (rlen <= 0 || vlen <= 0) state_d = rdt_pkg::StOutOff;
        else state_d = rdt_pkg::StVelMul;
      end
      rdt_pkg::StVelMul:  state_d = rdt_pkg::StVelDiv;
      rdt_pkg::StVelDiv:  if (cnt_q == 6'd0) state_d = rdt_pkg::StOutOff;
      rdt_pkg::StOutOff:  if (out_acc) state_d = rdt_pkg::StOutOn;
      rdt_pkg::StOutOn:   if (out_acc) state_d = rdt_pkg::StIdle;
      default:            state_d = rdt_pkg::StIdle;
    endcase
  end

  // datapath and window update
  always_comb begin
    logic [SAMPLE_BITS-1:0] raw;
    logic [SumW:0] acc;
    logic [32:0] msq;
    logic [34:0] vq;
    logic [18:0] trial;
    sum_d = sum_q; fill_d = fill_q; hold_cnt_d = hold_cnt_q; hold_act_d = hold_act_q;
    mag_d = mag_q; sq_d = sq_q; x_d = x_q; msb_d = msb_q; m_d = m_q; bit_d = bit_q;
    r_d = r_q; pass_d = pass_q; lsum_d = lsum_q; prod_d = prod_q; db_d = db_q;
    num_d = num_q; cnt_d = cnt_q; rem_d = rem_q; vel_d = vel_q;
    mul_a = '0; mul_b = '0;
    raw = sample_i;
    acc = '0; msq = '0; vq = '0; trial = '0;
    unique case (state_q)
      rdt_pkg::StIdle: begin
        // magnitude of the sample; most negative code maps to 2^(B-1)
        mag_d = raw[SAMPLE_BITS-1] ? (~raw + 1'b1) : raw;
      end
      rdt_pkg::StSquare: begin
        mul_a = 33'(mag_q); mul_b = 33'(mag_q);
        sq_d = SqW'(mul_p);
        // hold-off handling
        if (hold_act_q && hold_cnt_q < hold_len_q) begin
          hold_cnt_d = hold_cnt_q + 16'd1;
        end else if (hold_act_q) begin
          hold_act_d = 1'b0; hold_cnt_d = '0; sum_d = '0; fill_d = '0;
        end
      end
      rdt_pkg::StAccum: begin
        if (!(hold_act_q)) begin
          if (fill_q < eff_n) begin
            acc = {1'b0, sum_q} + (SumW+1)'(sq_q);
            sum_d = acc[SumW] ? '1 : acc[SumW-1:0];
            fill_d = fill_q + 1'b1;
          end else if (sum_q == '0) begin
            fill_d = '0;
          end else begin
            x_d = sum_q; msb_d = 7'd63; pass_d = 1'b0; r_d = '0;
          end
        end
      end
      rdt_pkg::StNorm: begin
        // find MSB one bit per cycle
        if (!(x_q[SumW-1] || msb_q == 7'd0)) begin
          x_d = {x_q[SumW-2:0], 1'b0}; msb_d = msb_q - 7'd1;
        end else begin
          m_d = {1'b0, x_q[SumW-1:SumW-32]};
          r_d = signed'(32'(msb_q)) <<< 16;
          bit_d = 5'd15;
        end
      end
      rdt_pkg::StLogSq: begin
        mul_a = m_q; mul_b = m_q;
        prod_d = mul_p;
      end
      rdt_pkg::StLogStep: begin
        msq = 33'(prod_q >> 31);
        if (msq[32]) begin
          m_d = msq >> 1; r_d = r_q + (32'sd1 <<< bit_q);
        end else m_d = msq;
        bit_d = bit_q - 5'd1;
        if (bit_q == 5'd0 && !pass_q) begin
          lsum_d = msq[32] ? r_q + 32'sd1 : r_q;
          pass_d = 1'b1;
          x_d = {{(SumW-WinW){1'b0}}, win_clip};
          msb_d = 7'd63;
        end
      end
      rdt_pkg::StLevel: begin
        prod_d = 66'((lvl > 0) ? 32'sd0 : -lvl);
      end
      rdt_pkg::StDbMul: begin
        mul_a = prod_q[32:0]; mul_b = 33'(rdt_pkg::DbScale);
        db_d = -18'(signed'({1'b0, 34'((mul_p + 66'h80000000) >> 32)}));
        if (db_d < 18'(thr_q)) begin
          sum_d = '0; fill_d = '0;
        end else begin
          vel_d = '0; hold_act_d = 1'b1;
        end
      end
      rdt_pkg::StVelMul: begin
        mul_a = 33'(dnum); mul_b = 33'(vlen[7:0]);
        num_d = 25'(mul_p);
        rem_d = '0; cnt_d = 6'd25;
      end
      rdt_pkg::StVelDiv: begin
        // restoring division, one quotient bit per cycle
        if (cnt_q != 6'd0) begin
          trial = {rem_q, num_q[24]} - 19'(rlen);
          if (!trial[18]) begin
            rem_d = trial[17:0]; num_d = {num_q[23:0], 1'b1};
          end else begin
            rem_d = {rem_q[16:0], num_q[24]}; num_d = {num_q[23:0], 1'b0};
          end
          cnt_d = cnt_q - 6'd1;
        end else begin
          vq = 35'(num_q) + 35'(vmin_q);
          vel_d = vq[6:0];
        end
      end
      default: ;
    endcase
    // a change of the effective window length empties the window and ends the hold-off
    if (cfg_we_i && cfg_idx_i == rdt_pkg::RegWindowLen && eff_new != eff_n) begin
      sum_d = '0; fill_d = '0; hold_cnt_d = '0; hold_act_d = 1'b0;
    end
  end

  // outputs
  always_comb begin
    result_valid_o = (state_q == rdt_pkg::StOutOff) || (state_q == rdt_pkg::StOutOn);
    last_o         = (state_q == rdt_pkg::StOutOn);
    status_byte_o  = last_o ? rdt_pkg::StatusNoteOn : rdt_pkg::StatusNoteOff;
    note_o         = note_q;
    velocity_o     = last_o ? vel_q : 7'd0;
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_len_q <= 13'd480; hold_len_q <= 16'd4800;
      thr_q <= -17'sd5120; ceil_q <= '0;
      vmin_q <= 7'd1; vmax_q <= 7'd127; note_q <= 7'd36;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rdt_pkg::RegWindowLen:  win_len_q  <= cfg_data_i[12:0];
        rdt_pkg::RegHoldoffLen: hold_len_q <= cfg_data_i[15:0];
        rdt_pkg::RegThreshold:  thr_q      <= signed'(cfg_data_i);
        rdt_pkg::RegCeiling:    ceil_q     <= signed'(cfg_data_i);
        rdt_pkg::RegVelMin:     vmin_q     <= cfg_data_i[6:0];
        rdt_pkg::RegVelMax:     vmax_q     <= cfg_data_i[6:0];
        rdt_pkg::RegNote:       note_q     <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rdt_pkg::StIdle;
      sum_q <= '0; fill_q <= '0; hold_cnt_q <= '0; hold_act_q <= 1'b0;
    end else begin
      state_q <= state_d;
      sum_q <= sum_d; fill_q <= fill_d; hold_cnt_q <= hold_cnt_d; hold_act_q <= hold_act_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    mag_q <= mag_d; sq_q <= sq_d; x_q <= x_d; msb_q <= msb_d; m_q <= m_d;
    bit_q <= bit_d; r_q <= r_d; pass_q <= pass_d; lsum_q <= lsum_d;
    prod_q <= prod_d; db_q <= db_d; num_q <= num_d; cnt_q <= cnt_d;
    rem_q <= rem_d; vel_q <= vel_d;
  end

  // checks
  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> sample_stall_o) else $error("result while ready");
  a_on_after_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rdt_pkg::StOutOff && out_acc) |=> (result_valid_o && last_o))
    else $error("note-on missing");
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= WinW'(MAX_WINDOW)) else $error("fill overrun");

endmodule

`default_nettype wire

@@ test/rms_drum_trigger_core_tb.sv @@
// ----------------------------------------------------------------------------
// rms_drum_trigger_core_tb: self-checking bench for the RMS drum trigger
// Streams audio samples through the sample channel, predicts every note-off
// and note-on transaction, and checks them field by field on the result side
// under random idling, a long receiver hold-off and many register settings.
// ----------------------------------------------------------------------------
`default_nettype none

module rms_drum_trigger_core_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxWindow  = 4096;
  localparam int unsigned SampleBits = 24;
  localparam int unsigned TailCycles = 400;

  typedef struct packed {
    logic [7:0] status_byte;
    logic [6:0] note;
    logic [6:0] velocity;
    logic       last;
  } note_msg_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic sample_valid_i = 1'b0;
  logic sample_stall_o;
  logic signed [SampleBits-1:0] sample_i = '0;
  logic result_valid_o;
  logic result_stall_i = 1'b0;
  logic [7:0] status_byte_o;
  logic [6:0] note_o;
  logic [6:0] velocity_o;
  logic last_o;
  logic cfg_we_i = 1'b0;
  logic [rdt_pkg::CfgIdxW-1:0] cfg_idx_i = '0;
  logic [rdt_pkg::CfgDataW-1:0] cfg_data_i = '0;

  rms_drum_trigger_core #(
    .MAX_WINDOW (MaxWindow),
    .SAMPLE_BITS(SampleBits)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .sample_valid_i(sample_valid_i),
    .sample_stall_o(sample_stall_o),
    .sample_i      (sample_i),
    .result_valid_o(result_valid_o),
    .result_stall_i(result_stall_i),
    .status_byte_o (status_byte_o),
    .note_o        (note_o),
    .velocity_o    (velocity_o),
    .last_o        (last_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  // Detector copy: registers and window state
  int unsigned win_len, hold_len, vel_lo, vel_hi, note_num;
  longint thresh_db, ceil_db;
  longint unsigned sq_sum;
  int unsigned fill_cnt, hold_cnt;
  bit hold_on;

  logic signed [SampleBits-1:0] sample_queue[$];
  note_msg_t note_msgs_due[$];
  int errors = 0;
  int notes_seen = 0;
  bit no_idle = 1'b0;
  int hold_trig = 0;
  int hold_seen = 0;
  int hold_left = 0;

  function automatic int unsigned clamp_window(int unsigned w);
    if (w < 1) return 1;
    if (w > MaxWindow) return MaxWindow;
    return w;
  endfunction

  // log2 in Q16: integer part from the MSB, fraction by repeated squaring
  function automatic longint log2_fix(longint unsigned x);
    int msb;
    longint unsigned m;
    longint r;
    msb = 63;
    while (msb > 0 && x[msb] == 1'b0) msb--;
    if (msb <= 31) m = x << (31 - msb);
    else m = x >> (msb - 31);
    r = longint'(msb) * 65536;
    for (int i = 15; i >= 0; i--) begin
      m = (m * m) >> 31;
      if (m >= 64'h1_0000_0000) begin
        m = m >> 1;
        r += longint'(1) << i;
      end
    end
    return r;
  endfunction

  function automatic void clear_window();
    sq_sum = 0;
    fill_cnt = 0;
  endfunction

  function automatic void reset_detector();
    win_len = 480;
    hold_len = 4800;
    thresh_db = -5120;
    ceil_db = 0;
    vel_lo = 1;
    vel_hi = 127;
    note_num = 36;
    clear_window();
    hold_cnt = 0;
    hold_on = 1'b0;
  endfunction

  // Work out the notes caused by one accepted sample
  function automatic void predict_notes(logic signed [SampleBits-1:0] s);
    int unsigned n;
    longint unsigned mag;
    longint lvl, db, vel, rlen, vlen;
    note_msg_t msg;
    n = clamp_window(win_len);
    if (hold_on) begin
      if (hold_cnt >= hold_len) begin
        hold_on = 1'b0;
        hold_cnt = 0;
        clear_window();
      end else begin
        hold_cnt = (hold_cnt + 1) & 16'hFFFF;
        return;
      end
    end
    if (fill_cnt < n) begin
      mag = (s < 0) ? longint'(-longint'(s)) : longint'(s);
      sq_sum += mag * mag;
      fill_cnt++;
      return;
    end
    if (sq_sum == 0) begin
      clear_window();
      return;
    end
    lvl = log2_fix(sq_sum) - log2_fix(n) - longint'(2 * SampleBits - 2) * 65536;
    if (lvl > 0) lvl = 0;
    db = -longint'((longint'(-lvl) * longint'(rdt_pkg::DbScale) + 64'h8000_0000) >> 32);
    if (db < thresh_db) begin
      clear_window();
      return;
    end
    if (db > ceil_db) db = ceil_db;
    rlen = ceil_db - thresh_db;
    vlen = longint'(vel_hi) - longint'(vel_lo);
    if (rlen <= 0 || vlen <= 0) vel = 0;
    else vel = ((db - thresh_db) * vlen) / rlen + longint'(vel_lo);
    msg = '{rdt_pkg::StatusNoteOff, note_num[6:0], 7'd0, 1'b0};
    note_msgs_due.push_back(msg);
    msg = '{rdt_pkg::StatusNoteOn, note_num[6:0], vel[6:0], 1'b1};
    note_msgs_due.push_back(msg);
    hold_on = 1'b1;
  endfunction

  // Sample driver: hold a stalled transaction, idle now and then
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_valid_i <= 1'b0;
      sample_i <= '0;
    end else begin
      if (sample_valid_i && !sample_stall_o) predict_notes(sample_i);
      if (!sample_valid_i || !sample_stall_o) begin
        if (sample_queue.size() > 0 && (no_idle || $urandom_range(99) >= 8)) begin
          sample_valid_i <= 1'b1;
          sample_i <= sample_queue.pop_front();
        end else begin
          sample_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor: check each transaction, stall at random or for a long stretch
  always @(posedge clk_i or negedge rst_ni) begin
    note_msg_t want;
    if (!rst_ni) begin
      result_stall_i <= 1'b0;
    end else begin
      if (result_valid_o && !result_stall_i) begin
        notes_seen++;
        if (note_msgs_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected note status=%0h note=%0d vel=%0d last=%0b", $time,
                   status_byte_o, note_o, velocity_o, last_o);
        end else begin
          want = note_msgs_due.pop_front();
          if (status_byte_o !== want.status_byte) begin
            errors++;
            $display("%0t: status_byte expected %0h actual %0h", $time,
                     want.status_byte, status_byte_o);
          end
          if (note_o !== want.note) begin
            errors++;
            $display("%0t: note expected %0d actual %0d", $time, want.note, note_o);
          end
          if (velocity_o !== want.velocity) begin
            errors++;
            $display("%0t: velocity expected %0d actual %0d", $time,
                     want.velocity, velocity_o);
          end
          if (last_o !== want.last) begin
            errors++;
            $display("%0t: last expected %0b actual %0b", $time, want.last, last_o);
          end
        end
      end
      if (hold_seen != hold_trig) begin
        hold_seen <= hold_trig;
        hold_left <= 800;
        result_stall_i <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        result_stall_i <= 1'b1;
      end else begin
        result_stall_i <= !no_idle && ($urandom_range(99) < 8);
      end
    end
  end

  // Register write; the port is lowered by end_cfg
  task automatic write_reg(logic [rdt_pkg::CfgIdxW-1:0] idx,
                           logic [rdt_pkg::CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    case (idx)
      rdt_pkg::RegWindowLen: begin
        if (clamp_window(data[12:0]) != clamp_window(win_len)) begin
          clear_window();
          hold_cnt = 0;
          hold_on = 1'b0;
        end
        win_len = data[12:0];
      end
      rdt_pkg::RegHoldoffLen: hold_len = data[15:0];
      rdt_pkg::RegThreshold:  thresh_db = longint'($signed(data));
      rdt_pkg::RegCeiling:    ceil_db = longint'($signed(data));
      rdt_pkg::RegVelMin:     vel_lo = data[6:0];
      rdt_pkg::RegVelMax:     vel_hi = data[6:0];
      rdt_pkg::RegNote:       note_num = data[6:0];
      default: ;
    endcase
  endtask

  task automatic end_cfg();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Wait until every sample is taken and every note has come, then let it settle
  task automatic drain();
    while (sample_queue.size() > 0 || sample_valid_i || note_msgs_due.size() > 0)
      @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
  endtask

  function automatic logic signed [SampleBits-1:0] rand_sample(int shift);
    logic signed [SampleBits-1:0] v;
    v = SampleBits'($urandom);
    return v >>> shift;
  endfunction

  // Push a burst of bursts: each one fills a window at one loudness
  function automatic int push_bursts(int total);
    int pushed, len, shift;
    pushed = 0;
    while (pushed < total) begin
      len = clamp_window(win_len) + 1 + $urandom_range(0, 2);
      shift = $urandom_range(0, 23);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(19) == 0) sample_queue.push_back($urandom_range(1) ? 
            24'sh7FFFFF : 24'sh800000);
        else if ($urandom_range(19) == 0) sample_queue.push_back('0);
        else sample_queue.push_back(rand_sample(shift));
      end
      pushed += len;
    end
    return pushed;
  endfunction

  function automatic logic [rdt_pkg::CfgDataW-1:0] rand_db();
    int v;
    case ($urandom_range(5))
      0: v = 0;
      1: v = -36864;
      default: v = -int'($urandom_range(0, 36864));
    endcase
    return v[rdt_pkg::CfgDataW-1:0];
  endfunction

  initial begin
    int sent, phase;
    logic [rdt_pkg::CfgDataW-1:0] wl;
    reset_detector();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: full-scale extremes, lowest threshold, widest velocity span
    write_reg(rdt_pkg::RegWindowLen, 17'd4);
    write_reg(rdt_pkg::RegHoldoffLen, 17'd2);
    write_reg(rdt_pkg::RegThreshold, 17'h11000);
    write_reg(rdt_pkg::RegCeiling, 17'd0);
    write_reg(rdt_pkg::RegVelMin, 17'd0);
    write_reg(rdt_pkg::RegVelMax, 17'd127);
    write_reg(rdt_pkg::RegNote, 17'd127);
    end_cfg();
    repeat (5) sample_queue.push_back(24'sh7FFFFF);
    repeat (2) sample_queue.push_back(24'sh000001);
    repeat (5) sample_queue.push_back(24'sh800000);
    repeat (2) sample_queue.push_back('0);
    repeat (5) sample_queue.push_back('0);   // silent window
    repeat (5) sample_queue.push_back(-24'sd1);
    drain();

    // Directed: clamped-low window, top threshold, only full scale fires
    write_reg(rdt_pkg::RegWindowLen, 17'd0);
    write_reg(rdt_pkg::RegHoldoffLen, 17'd0);
    write_reg(rdt_pkg::RegThreshold, 17'd0);
    write_reg(rdt_pkg::RegNote, 17'd0);
    end_cfg();
    repeat (4) sample_queue.push_back(24'sh800000);
    repeat (4) sample_queue.push_back(24'sh7FFFFF);
    drain();

    // Directed: same effective window, inverted spans give zero velocity
    write_reg(rdt_pkg::RegWindowLen, 17'd1);
    write_reg(rdt_pkg::RegThreshold, 17'h11000);
    write_reg(rdt_pkg::RegCeiling, 17'h11000 - 17'd1);
    write_reg(rdt_pkg::RegVelMin, 17'd127);
    write_reg(rdt_pkg::RegVelMax, 17'd0);
    end_cfg();
    repeat (6) sample_queue.push_back(24'sh400000);
    drain();

    // Random phases
    sent = 0;
    phase = 0;
    while (sent < 1700) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5, 6: wl = 17'($urandom_range(1, 16));
        7, 8: wl = 17'($urandom_range(17, 64));
        default: wl = 17'($urandom_range(0, 1));
      endcase
      write_reg(rdt_pkg::RegWindowLen, wl);
      write_reg(rdt_pkg::RegHoldoffLen,
                ($urandom_range(7) == 0) ? 17'd0 : 17'($urandom_range(1, 20)));
      write_reg(rdt_pkg::RegThreshold, rand_db());
      write_reg(rdt_pkg::RegCeiling, rand_db());
      write_reg(rdt_pkg::RegVelMin, 17'($urandom_range(0, 127)));
      write_reg(rdt_pkg::RegVelMax, 17'($urandom_range(0, 127)));
      write_reg(rdt_pkg::RegNote, 17'($urandom_range(0, 127)));
      end_cfg();
      no_idle = (phase == 3);
      if (phase == 5) hold_trig++;
      sent += push_bursts(120);
      drain();
      phase++;
    end
    no_idle = 1'b0;

    // Largest window, clamped from above; it only partly fills
    write_reg(rdt_pkg::RegWindowLen, 17'd8191);
    write_reg(rdt_pkg::RegHoldoffLen, 17'd65535);
    write_reg(rdt_pkg::RegThreshold, 17'h11000);
    end_cfg();
    repeat (40) sample_queue.push_back(rand_sample(0));
    repeat (20) sample_queue.push_back(rand_sample(2));
    drain();

    if (errors == 0 && note_msgs_due.size() == 0) begin
      $display("rms_drum_trigger_core_tb: clean");
    end else begin
      $display("rms_drum_trigger_core_tb: errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #100ms;
    $display("rms_drum_trigger_core_tb: errors");
    $finish;
  end

endmodule

`default_nettype wire
